/* rtl/core/pod_pkg.sv */
// Shared constants and helpers for the password obfuscation decoder.
// No dependencies; used by rtl/core/password_obfuscation_decoder.sv.
package pod_pkg;

  localparam logic [6:0] OFFSET_START = 7'h21;
  localparam logic [7:0] WRAP_ADD     = 8'h5e;
  localparam logic [5:0] SIX_MASK     = 6'h3f;
  localparam logic [3:0] BYTE_BITS    = 4'd8;
  localparam logic [3:0] PAIR_BITS    = 4'd6;

  localparam logic [6:0] OFFSET_30 = 7'h30;
  localparam logic [6:0] OFFSET_40 = 7'h40;
  localparam logic [6:0] OFFSET_50 = 7'h50;
  localparam logic [6:0] OFFSET_60 = 7'h60;
  localparam logic [6:0] OFFSET_70 = 7'h70;

  // Step the rolling offset through its cycle; wrap to the start value.
  function automatic logic [6:0] next_offset(input logic [6:0] o);
    logic [6:0] n;
    if (o < OFFSET_30) begin
      n = OFFSET_30;
    end else if (o < OFFSET_40) begin
      n = OFFSET_40;
    end else if (o < OFFSET_50) begin
      n = OFFSET_50;
    end else if (o < OFFSET_60) begin
      n = OFFSET_60;
    end else if (o < OFFSET_70) begin
      n = OFFSET_70;
    end else begin
      n = OFFSET_START;
    end
    return n;
  endfunction

endpackage

/* rtl/core/password_obfuscation_decoder.sv */
// Top level of the password obfuscation decoder: input register, decode
// logic, state and result register. Depends on rtl/core/pod_pkg.sv.
//
//   channel | direction | tdata                         | tuser     | tlast
//   in_     | slave     | [7:0] enc_char                | -         | last_char
//   out_    | master    | [7:0] out_byte, [8] check_ok  | is_status | -
//
// Each encoded character is held in the input register; the edge that
// decodes it also updates the string state and loads the result register.
// One character is taken per cycle, sustained, while the result side does not stall.
// rst_n is synchronous and active low; it clears all control and string state.
// A stalled result holds the result register; the input register then holds
// its character and in_tready falls until the result transfer frees the slot.
module password_obfuscation_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] enc_char
  input  logic        in_tlast,   // last_char
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [8] check_ok, [15:9] zero
  output logic        out_tuser   // is_status
);

  // input register
  logic       in_vld_r,  in_vld_nxt;
  logic [7:0] in_char_r;
  logic       in_last_r;

  // string state
  logic [6:0] offset_r,    offset_nxt;
  logic       at_start_r,  at_start_nxt;
  logic       odd_r,       odd_nxt;
  logic [5:0] first_r,     first_nxt;
  logic [5:0] held_r,      held_nxt;
  logic [5:0] pend_bits_r, pend_bits_nxt;
  logic [2:0] pend_cnt_r,  pend_cnt_nxt;

  // result register
  logic       out_vld_r,    out_vld_nxt;
  logic [7:0] out_byte_r,   out_byte_nxt;
  logic       out_status_r, out_status_nxt;
  logic       out_ok_r,     out_ok_nxt;

  logic        advance;
  logic        in_xfer;
  logic        wrap;
  logic [5:0]  val;
  logic [5:0]  pair_diff;
  logic [11:0] acc;
  logic [3:0]  total;
  logic [2:0]  rest;
  logic [5:0]  keep_mask;
  logic [11:0] acc_shift;
  logic [5:0]  first_sel;

  // Decode the held character when the result slot is free or draining.
  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  // Shift back by the rolling offset, folding below-offset characters.
  always_comb begin
    wrap = ({1'b0, in_char_r} < {2'b00, offset_r});
    val  = in_char_r[5:0] - offset_r[5:0] + (wrap ? pod_pkg::WRAP_ADD[5:0] : 6'h00);
  end

  // Pair difference packed MSB first behind the pending bits.
  always_comb begin
    pair_diff = held_r - val;
    acc       = {pend_bits_r, pair_diff};
    total     = {1'b0, pend_cnt_r} + pod_pkg::PAIR_BITS;
    rest      = total[2:0];
    acc_shift = acc >> rest;
    keep_mask = ~(pod_pkg::SIX_MASK << rest);
    first_sel = at_start_r ? val : first_r;
  end

  always_comb begin
    in_vld_nxt     = in_xfer ? 1'b1 : (advance ? 1'b0 : in_vld_r);
    offset_nxt     = offset_r;
    at_start_nxt   = at_start_r;
    odd_nxt        = odd_r;
    first_nxt      = first_r;
    held_nxt       = held_r;
    pend_bits_nxt  = pend_bits_r;
    pend_cnt_nxt   = pend_cnt_r;
    out_vld_nxt    = (out_vld_r && !out_tready) ? 1'b1 : 1'b0;
    out_byte_nxt   = out_byte_r;
    out_status_nxt = out_status_r;
    out_ok_nxt     = out_ok_r;

    if (advance) begin
      offset_nxt = pod_pkg::next_offset(offset_r);
      if (in_last_r) begin
        // End of string: emit status and return to the reset state.
        out_vld_nxt    = 1'b1;
        out_byte_nxt   = 8'h00;
        out_status_nxt = 1'b1;
        out_ok_nxt     = ((first_sel ^ val) == pod_pkg::SIX_MASK);
        offset_nxt     = pod_pkg::OFFSET_START;
        at_start_nxt   = 1'b1;
        odd_nxt        = 1'b0;
        first_nxt      = 6'h00;
        held_nxt       = 6'h00;
        pend_bits_nxt  = 6'h00;
        pend_cnt_nxt   = 3'd0;
      end else if (at_start_r) begin
        first_nxt    = val;
        at_start_nxt = 1'b0;
        odd_nxt      = 1'b1;
      end else if (odd_r) begin
        held_nxt = val;
        odd_nxt  = 1'b0;
      end else begin
        odd_nxt = 1'b1;
        if (total >= pod_pkg::BYTE_BITS) begin
          // A full byte is ready; keep the low leftover bits.
          out_vld_nxt    = 1'b1;
          out_byte_nxt   = acc_shift[7:0];
          out_status_nxt = 1'b0;
          out_ok_nxt     = 1'b0;
          pend_cnt_nxt   = rest;
          pend_bits_nxt  = acc[5:0] & keep_mask;
        end else begin
          pend_cnt_nxt  = total[2:0];
          pend_bits_nxt = acc[5:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      offset_r    <= pod_pkg::OFFSET_START;
      at_start_r  <= 1'b1;
      odd_r       <= 1'b0;
      first_r     <= 6'h00;
      held_r      <= 6'h00;
      pend_bits_r <= 6'h00;
      pend_cnt_r  <= 3'd0;
    end else begin
      in_vld_r    <= in_vld_nxt;
      out_vld_r   <= out_vld_nxt;
      offset_r    <= offset_nxt;
      at_start_r  <= at_start_nxt;
      odd_r       <= odd_nxt;
      first_r     <= first_nxt;
      held_r      <= held_nxt;
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

  // Payload registers: load only on transfer or decode.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    out_byte_r   <= out_byte_nxt;
    out_status_r <= out_status_nxt;
    out_ok_r     <= out_ok_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'b0000000, out_ok_r, out_byte_r};
  assign out_tuser  = out_status_r;

endmodule

/* rtl/core/pod_checker.sv */
// Port-level checks for the password obfuscation decoder, bound to the top.
// Depends only on the top level's ports.
module pod_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);

  // Drop any result while in reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // An empty result slot never back-pressures the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result slot");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule

bind password_obfuscation_decoder pod_checker u_pod_checker (.*);

/* tb/password_obfuscation_decoder_tb.sv */
// Self-checking testbench for password_obfuscation_decoder: directed strings, then
// random well-formed and noisy strings, with bursty input and a stalling result side.
// Depends on rtl/core/pod_pkg.sv and rtl/core/password_obfuscation_decoder.sv.
module password_obfuscation_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One decoded result as it leaves the block.
  typedef struct packed {
    logic [7:0] data;
    logic       is_status;
    logic       check_ok;
  } decoded_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;  // [7:0] enc_char
  logic        in_tlast = 1'b0;   // last_char
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [7:0] out_byte, [8] check_ok, [15:9] zero
  logic        out_tuser;         // is_status

  // Expected results, oldest first.
  decoded_t decoded_q[$];
  int       fail_count = 0;

  // Decoder state as the block should hold it.
  logic [6:0] dec_offset;
  bit         dec_at_start;
  bit         dec_odd;
  logic [5:0] dec_first;
  logic [5:0] dec_held;
  logic [5:0] dec_pend_bits;
  logic [2:0] dec_pend_cnt;

  // Sender burst bookkeeping.
  int burst_left = 0;

  // Receiver stall pattern.
  int rx_cycle = 0;
  int rx_mode = 0;

  password_obfuscation_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the handshakes hang.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Return the string state to its start-of-string values.
  task automatic clear_decoder();
    dec_offset    = pod_pkg::OFFSET_START;
    dec_at_start  = 1'b1;
    dec_odd       = 1'b0;
    dec_first     = '0;
    dec_held      = '0;
    dec_pend_bits = '0;
    dec_pend_cnt  = '0;
  endtask

  // Advance the rolling offset: 0x21 -> 0x30 -> ... -> 0x70 -> 0x21.
  function automatic logic [6:0] advance_offset(input logic [6:0] o);
    logic [6:0] n;
    if (o >= pod_pkg::OFFSET_70) begin
      n = pod_pkg::OFFSET_START;
    end else if (o < pod_pkg::OFFSET_30) begin
      n = pod_pkg::OFFSET_30;
    end else begin
      n = {o[6:4] + 3'd1, 4'h0};
    end
    return n;
  endfunction

  // Decode one accepted character and queue whatever result it causes.
  task automatic decode_char(input logic [7:0] c, input logic last);
    logic [8:0]  shifted;
    logic [5:0]  v;
    logic [5:0]  first;
    logic [5:0]  diff;
    logic [11:0] acc;
    logic [3:0]  total;
    logic [3:0]  rest;
    decoded_t    res;
    // Only the low six bits matter, so borrow out of the subtraction is harmless.
    shifted = {1'b0, c} + ((c < {1'b0, dec_offset}) ? {1'b0, pod_pkg::WRAP_ADD} : 9'd0)
              - {2'b00, dec_offset};
    v = shifted[5:0];
    dec_offset = advance_offset(dec_offset);
    if (last) begin
      first = dec_at_start ? v : dec_first;
      res.data      = 8'h00;
      res.is_status = 1'b1;
      res.check_ok  = ((first ^ v) == pod_pkg::SIX_MASK);
      decoded_q.push_back(res);
      clear_decoder();
    end else if (dec_at_start) begin
      dec_first    = v;
      dec_at_start = 1'b0;
      dec_odd      = 1'b1;
    end else if (dec_odd) begin
      dec_held = v;
      dec_odd  = 1'b0;
    end else begin
      dec_odd = 1'b1;
      diff  = dec_held - v;
      acc   = {dec_pend_bits, diff};
      total = {1'b0, dec_pend_cnt} + 4'd6;
      if (total >= 4'd8) begin
        rest = total - 4'd8;
        res.data      = 8'(acc >> rest);
        res.is_status = 1'b0;
        res.check_ok  = 1'b0;
        decoded_q.push_back(res);
        dec_pend_cnt  = rest[2:0];
        dec_pend_bits = 6'(acc & ((12'd1 << rest) - 12'd1));
      end else begin
        dec_pend_cnt  = total[2:0];
        dec_pend_bits = acc[5:0];
      end
    end
  endtask

  // Encode a 6-bit value for the next position, picking one of several aliases.
  function automatic logic [7:0] make_char(input logic [5:0] v);
    logic [8:0] c;
    int         k;
    c = {2'b00, dec_offset} + {3'b000, v};
    if (c >= {1'b0, pod_pkg::WRAP_ADD} && $urandom_range(0, 3) == 0) begin
      // Alias below the offset: decodes through the wrap path.
      c = c - {1'b0, pod_pkg::WRAP_ADD};
    end else begin
      k = $urandom_range(0, 2);
      repeat (k) begin
        if (c + 9'd64 <= 9'd255) c = c + 9'd64;
      end
    end
    return c[7:0];
  endfunction

  // Send one character; the sender idles only between bursts.
  task automatic send_char(input logic [7:0] c, input logic last);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 15) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_char(c, last);
    burst_left--;
  endtask

  // String kinds for the random part.
  typedef enum int {STR_VALID, STR_BROKEN, STR_RANDOM_CHECK, STR_NOISE} str_kind_t;

  // Send a whole string of the given kind.
  task automatic send_string(input int len, input str_kind_t kind);
    logic [5:0] first_v;
    logic [5:0] v;
    logic [7:0] c;
    logic       last;
    first_v = '0;
    for (int p = 0; p < len; p++) begin
      last = (p == len - 1);
      v = 6'($urandom);
      if (kind == STR_NOISE) begin
        c = 8'($urandom_range(0, 255));
      end else begin
        if (p == 0) first_v = v;
        if (last && p > 0 && kind == STR_VALID) v = first_v ^ pod_pkg::SIX_MASK;
        if (last && p > 0 && kind == STR_BROKEN) v = first_v ^ 6'h3e;
        c = make_char(v);
      end
      send_char(c, last);
    end
  endtask

  // Compare one result transfer with the oldest expectation.
  task automatic check_result();
    decoded_t want;
    if (decoded_q.size() == 0) begin
      $error("unexpected result: tdata %04h tuser %0b", out_tdata, out_tuser);
      fail_count++;
    end else begin
      want = decoded_q.pop_front();
      if (out_tdata[7:0] !== want.data) begin
        $error("out_byte: expected %02h, got %02h", want.data, out_tdata[7:0]);
        fail_count++;
      end
      if (out_tuser !== want.is_status) begin
        $error("is_status: expected %0b, got %0b", want.is_status, out_tuser);
        fail_count++;
      end
      if (out_tdata[8] !== want.check_ok) begin
        $error("check_ok: expected %0b, got %0b", want.check_ok, out_tdata[8]);
        fail_count++;
      end
      if (out_tdata[15:9] !== 7'd0) begin
        $error("tdata padding: expected 00, got %02h", out_tdata[15:9]);
        fail_count++;
      end
    end
  endtask

  // Result side: check each transfer, then pick the next ready value.
  // The stall pattern is redrawn periodically among: always ready, coin flip,
  // mostly stalled, or a fixed one-in-three stall.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result();
    if (rx_cycle % 256 == 0) rx_mode = $urandom_range(0, 3);
    rx_cycle++;
    case (rx_mode)
      0: begin
        out_tready <= 1'b1;
      end
      1: begin
        out_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_tready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_tready <= (rx_cycle % 3 != 0);
      end
    endcase
  end

  // A string of one character is first and last at once: check fails.
  task automatic test_single_char();
    send_char(8'h00, 1'b1);
    send_char(8'hff, 1'b1);
  endtask

  // Two characters whose values are complements: check passes, no data.
  task automatic test_short_valid();
    send_char(make_char(6'h05), 1'b0);
    send_char(make_char(6'h05 ^ pod_pkg::SIX_MASK), 1'b1);
  endtask

  // Byte extremes, last at an even position: one pair's six bits are dropped.
  task automatic test_extremes_even_last();
    send_char(8'hff, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hff, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'h00, 1'b1);
  endtask

  // Ten characters: four pairs give three whole bytes, offset wraps once,
  // and the last one closes a valid check.
  task automatic test_full_bytes();
    logic [5:0] first_v;
    logic [5:0] v;
    first_v = 6'h2a;
    for (int p = 0; p < 10; p++) begin
      v = (p == 0) ? first_v : 6'(p * 13 + 7);
      if (p == 9) v = first_v ^ pod_pkg::SIX_MASK;
      send_char(make_char(v), p == 9);
    end
  endtask

  // Mostly well-formed strings with random content, plus broken and noisy ones.
  task automatic test_random_strings();
    int        sent;
    int        len;
    int        pick;
    str_kind_t kind;
    sent = 0;
    while (sent < 1200) begin
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
      pick = $urandom_range(0, 99);
      if (pick < 55) kind = STR_VALID;
      else if (pick < 70) kind = STR_BROKEN;
      else if (pick < 85) kind = STR_RANDOM_CHECK;
      else kind = STR_NOISE;
      send_string(len, kind);
      sent += len;
    end
  endtask

  initial begin
    clear_decoder();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_single_char();
    test_short_valid();
    test_extremes_even_last();
    test_full_bytes();
    test_random_strings();

    // Drop valid, drain the result side, then allow the pipeline to settle.
    in_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
